/* rtl/scsa_pkg.sv */
`default_nettype none
package scsa_pkg;
	localparam int PAGE_BYTES = 65536;
	localparam int POOL_PAGES = 16;
	localparam int CLASS_COUNT = 16;
	localparam int PAGE_W = $clog2(PAGE_BYTES);
	localparam int PG_W = $clog2(POOL_PAGES);
	localparam int OFF_W = PAGE_W + PG_W;
	localparam int UNIT_W = OFF_W - 4;
	localparam int LINK_DEPTH = POOL_PAGES * (PAGE_BYTES / 16);
	localparam int CNT_W = $clog2(POOL_PAGES + 1);
	localparam int REM_W = PAGE_W - 5;
	localparam int ADDR_W = 48;
	localparam int SIZE_W = 32;
	localparam int CLS_W = 4;

	localparam int CARVE_BYTES = PAGE_BYTES - 64;
	localparam int BLK_0 = CARVE_BYTES / 48;
	localparam int BLK_1 = CARVE_BYTES / 80;
	localparam int BLK_2 = CARVE_BYTES / 112;
	localparam int BLK_3 = CARVE_BYTES / 144;
	localparam int BLK_4 = CARVE_BYTES / 208;
	localparam int BLK_5 = CARVE_BYTES / 272;
	localparam int BLK_6 = CARVE_BYTES / 400;
	localparam int BLK_7 = CARVE_BYTES / 528;
	localparam int BLK_8 = CARVE_BYTES / 784;
	localparam int BLK_9 = CARVE_BYTES / 1040;
	localparam int BLK_10 = CARVE_BYTES / 1552;
	localparam int BLK_11 = CARVE_BYTES / 2064;
	localparam int BLK_12 = CARVE_BYTES / 3088;
	localparam int BLK_13 = CARVE_BYTES / 4112;
	localparam int BLK_14 = CARVE_BYTES / 6160;
	localparam int BLK_15 = CARVE_BYTES / 8208;

	localparam logic [1:0] ST_SLAB = 2'd0;
	localparam logic [1:0] ST_SYS = 2'd1;
	localparam logic [1:0] ST_FOREIGN = 2'd2;
	localparam logic [1:0] ST_NULL = 2'd3;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE = 1'b1;

	typedef struct packed {
		logic req;
		logic [1:0] status;
		logic [CLS_W-1:0] cls;
		logic [OFF_W-1:0] off;
	} cmd_t;

	function automatic logic [13:0] class_bytes(input logic [CLS_W-1:0] c);
		logic [13:0] r;
		case (c)
			4'd0: r = 14'd32;
			4'd1: r = 14'd64;
			4'd2: r = 14'd96;
			4'd3: r = 14'd128;
			4'd4: r = 14'd192;
			4'd5: r = 14'd256;
			4'd6: r = 14'd384;
			4'd7: r = 14'd512;
			4'd8: r = 14'd768;
			4'd9: r = 14'd1024;
			4'd10: r = 14'd1536;
			4'd11: r = 14'd2048;
			4'd12: r = 14'd3072;
			4'd13: r = 14'd4096;
			4'd14: r = 14'd6144;
			default: r = 14'd8192;
		endcase
		return r;
	endfunction

	function automatic logic [14:0] stride_of(input logic [CLS_W-1:0] c);
		return {1'b0, class_bytes(c)} + 15'd16;
	endfunction

	// blocks per page = (PAGE_BYTES-64)/stride, all classes
	function automatic logic [REM_W-1:0] blocks_of(input logic [CLS_W-1:0] c);
		logic [REM_W-1:0] r;
		case (c)
			4'd0: r = REM_W'(BLK_0);
			4'd1: r = REM_W'(BLK_1);
			4'd2: r = REM_W'(BLK_2);
			4'd3: r = REM_W'(BLK_3);
			4'd4: r = REM_W'(BLK_4);
			4'd5: r = REM_W'(BLK_5);
			4'd6: r = REM_W'(BLK_6);
			4'd7: r = REM_W'(BLK_7);
			4'd8: r = REM_W'(BLK_8);
			4'd9: r = REM_W'(BLK_9);
			4'd10: r = REM_W'(BLK_10);
			4'd11: r = REM_W'(BLK_11);
			4'd12: r = REM_W'(BLK_12);
			4'd13: r = REM_W'(BLK_13);
			4'd14: r = REM_W'(BLK_14);
			default: r = REM_W'(BLK_15);
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

/* rtl/scsa_front.sv */
`default_nettype none
module scsa_front import scsa_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [ADDR_W-1:0] pool_base,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic req_type,
	input wire logic [SIZE_W-1:0] alloc_size,
	input wire logic [ADDR_W-1:0] block_address,
	output logic q_valid,
	input wire logic q_stall,
	output cmd_t q_cmd
);
	// 2-entry queue
	cmd_t buf_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t c;
	logic [ADDR_W:0] diff;
	logic [ADDR_W-1:0] hdr;
	logic [3:0] cls;
	logic fit;

	always_comb begin
		c = '0;
		c.req = req_type;
		fit = 1'b0;
		cls = '0;
		hdr = block_address - ADDR_W'(16);
		diff = {1'b0, hdr} - {1'b0, pool_base};
		for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
			if (alloc_size <= SIZE_W'(class_bytes(CLS_W'(i)))) begin
				cls = CLS_W'(i);
				fit = 1'b1;
			end
		end
		if (req_type == REQ_ALLOC) begin
			c.cls = cls;
			c.status = fit ? ST_SLAB : ST_SYS;
		end else if (block_address == '0) begin
			c.status = ST_NULL;
		end else if ({1'b0, block_address} < {1'b0, pool_base} + (ADDR_W+1)'(16)
			|| diff[ADDR_W] || diff[ADDR_W-1:OFF_W] != '0) begin
			c.status = ST_FOREIGN;
		end else begin
			c.status = ST_SLAB;
			c.off = diff[OFF_W-1:0];
		end
	end

	assign in_stall = cnt_q == 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign q_cmd = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) buf_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (in_valid && !in_stall) wp_q <= !wp_q;
			if (q_valid && !q_stall) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(in_valid && !in_stall) - 2'(q_valid && !q_stall);
		end
	end
endmodule
`default_nettype wire

/* rtl/scsa_back.sv */
`default_nettype none
module scsa_back import scsa_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [ADDR_W-1:0] pool_base,
	input wire logic q_valid,
	output logic q_stall,
	input wire cmd_t q_cmd,
	output logic out_valid,
	input wire logic out_stall,
	output logic [ADDR_W-1:0] result_address,
	output logic [1:0] status,
	output logic [CLS_W-1:0] size_class
);
	localparam logic S_IDLE = 1'b0;
	localparam logic S_POP = 1'b1;

	logic state_q;
	cmd_t cmd_q;
	logic [CLASS_COUNT-1:0] head_v_q;
	logic [UNIT_W-1:0] head_q [CLASS_COUNT];
	logic [OFF_W-1:0] cur_q [CLASS_COUNT];
	logic [REM_W-1:0] rem_q [CLASS_COUNT];
	logic [POOL_PAGES-1:0] own_v_q;
	logic [CLS_W-1:0] own_q [POOL_PAGES];
	logic [CNT_W-1:0] claimed_q;
	logic [UNIT_W:0] link_mem [LINK_DEPTH];
	logic [UNIT_W:0] link_rd_q;
	logic ov_q;
	logic [ADDR_W-1:0] ra_q;
	logic [1:0] st_q;
	logic [CLS_W-1:0] sc_q;

	logic take, go;
	logic [PG_W-1:0] pg;
	logic [CLS_W-1:0] oc;
	logic lw;
	logic [UNIT_W-1:0] lw_a, lr_a;
	logic [UNIT_W:0] lw_d;

	assign q_stall = !(state_q == S_IDLE && (!ov_q || !out_stall));
	assign take = q_valid && !q_stall;
	assign go = state_q == S_POP;
	assign pg = cmd_q.off[OFF_W-1:PAGE_W];
	assign oc = own_q[pg];
	assign lr_a = head_q[q_cmd.cls];
	assign lw = go && cmd_q.req == REQ_FREE && cmd_q.status == ST_SLAB && own_v_q[pg];
	assign lw_a = cmd_q.off[OFF_W-1:4];
	assign lw_d = {head_v_q[oc], head_q[oc]};

	always_ff @(posedge clk) begin
		if (take) cmd_q <= q_cmd;
		if (take) link_rd_q <= link_mem[lr_a];
		if (lw) link_mem[lw_a] <= lw_d;
	end

	assign out_valid = ov_q;
	assign result_address = ra_q;
	assign status = st_q;
	assign size_class = sc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_v_q <= '0;
			own_v_q <= '0;
			claimed_q <= '0;
			ov_q <= 1'b0;
			for (int i = 0; i < CLASS_COUNT; i++) begin
				rem_q[i] <= '0;
				cur_q[i] <= '0;
				head_q[i] <= '0;
			end
			for (int i = 0; i < POOL_PAGES; i++) own_q[i] <= '0;
			ra_q <= '0;
			st_q <= ST_SLAB;
			sc_q <= '0;
		end else begin
			if (ov_q && !out_stall) ov_q <= 1'b0;
			if (take) state_q <= S_POP;
			if (go) begin
				state_q <= S_IDLE;
				ov_q <= 1'b1;
				ra_q <= '0;
				st_q <= cmd_q.status;
				sc_q <= '0;
				if (cmd_q.req == REQ_ALLOC && cmd_q.status == ST_SLAB) begin
					if (head_v_q[cmd_q.cls]) begin
						ra_q <= pool_base + ADDR_W'({head_q[cmd_q.cls], 4'd0}) + ADDR_W'(16);
						head_v_q[cmd_q.cls] <= link_rd_q[UNIT_W];
						head_q[cmd_q.cls] <= link_rd_q[UNIT_W-1:0];
						sc_q <= cmd_q.cls;
					end else if (rem_q[cmd_q.cls] != '0) begin
						ra_q <= pool_base + ADDR_W'(cur_q[cmd_q.cls]) + ADDR_W'(16);
						cur_q[cmd_q.cls] <= cur_q[cmd_q.cls] + OFF_W'(stride_of(cmd_q.cls));
						rem_q[cmd_q.cls] <= rem_q[cmd_q.cls] - 1'b1;
						sc_q <= cmd_q.cls;
					end else if (claimed_q < CNT_W'(POOL_PAGES)) begin
						ra_q <= pool_base + ADDR_W'({claimed_q[PG_W-1:0], PAGE_W'(64)})
							+ ADDR_W'(16);
						own_v_q[claimed_q[PG_W-1:0]] <= 1'b1;
						own_q[claimed_q[PG_W-1:0]] <= cmd_q.cls;
						claimed_q <= claimed_q + 1'b1;
						cur_q[cmd_q.cls] <= {claimed_q[PG_W-1:0], PAGE_W'(64)}
							+ OFF_W'(stride_of(cmd_q.cls));
						rem_q[cmd_q.cls] <= blocks_of(cmd_q.cls) - 1'b1;
						sc_q <= cmd_q.cls;
					end else begin
						st_q <= ST_SYS;
					end
				end else if (cmd_q.req == REQ_FREE && cmd_q.status == ST_SLAB) begin
					if (own_v_q[pg]) begin
						head_v_q[oc] <= 1'b1;
						head_q[oc] <= lw_a;
						sc_q <= oc;
					end else begin
						st_q <= ST_FOREIGN;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/size_class_slab_allocator_core.sv */
`default_nettype none
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | req_type, alloc_size, block_address
// out     | out_valid | out_stall | result_address, status, size_class
// cfg     | cfg_we    | -         | cfg_wdata (pool_base)
// Front classifies combinationally into a 2-entry queue; back reads the link memory,
// then does the head/link update, and takes no new item until that update is done.
// Reset clears all control state; the link memory is not cleared.
// Output register holds the result under out_stall; the back takes no new item while it waits.
module size_class_slab_allocator_core import scsa_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [ADDR_W-1:0] cfg_wdata,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic req_type,
	input wire logic [SIZE_W-1:0] alloc_size,
	input wire logic [ADDR_W-1:0] block_address,
	output logic out_valid,
	input wire logic out_stall,
	output logic [ADDR_W-1:0] result_address,
	output logic [1:0] status,
	output logic [CLS_W-1:0] size_class
);
	logic [ADDR_W-1:0] pool_base_q;
	logic qv, qs;
	cmd_t qc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pool_base_q <= '0;
		else if (cfg_we) pool_base_q <= cfg_wdata;
	end

	scsa_front u_front (
		.clk, .arst_n, .pool_base(pool_base_q), .in_valid, .in_stall,
		.req_type, .alloc_size, .block_address,
		.q_valid(qv), .q_stall(qs), .q_cmd(qc)
	);

	scsa_back u_back (
		.clk, .arst_n, .pool_base(pool_base_q), .q_valid(qv), .q_stall(qs),
		.q_cmd(qc), .out_valid, .out_stall, .result_address, .status, .size_class
	);
endmodule
`default_nettype wire
